@@ src/sspp_pkg.sv @@
package sspp_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam int unsigned CNT_W = 9;

	typedef enum logic [1:0] {
		ST_HUNT  = 2'd0,
		ST_SYNC1 = 2'd1,
		ST_FRAME = 2'd2
	} sync_state_t;

	typedef enum logic [1:0] {
		STAT_BUSY = 2'd0,
		STAT_DONE = 2'd1,
		STAT_BAD  = 2'd2
	} frame_status_t;

	typedef enum logic [2:0] {
		ROLE_IDLE  = 3'd0,
		ROLE_ID    = 3'd1,
		ROLE_LEN   = 3'd2,
		ROLE_ERR   = 3'd3,
		ROLE_PARAM = 3'd4,
		ROLE_CSUM  = 3'd5
	} byte_role_t;

	typedef struct packed {
		logic [1:0] frame_status;
		logic [2:0] byte_role;
		logic [7:0] param_index;
		logic [7:0] byte_value;
		logic [7:0] servo_error;
	} result_t;

endpackage

@@ src/sspp_if.sv @@
interface sspp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sspp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] frame_status;
	logic [2:0] byte_role;
	logic [7:0] param_index;
	logic [7:0] byte_value;
	logic [7:0] servo_error;

	modport source (
		output valid, output frame_status, output byte_role, output param_index,
		output byte_value, output servo_error, input ready
	);
	modport sink (
		input valid, input frame_status, input byte_role, input param_index,
		input byte_value, input servo_error, output ready
	);
endinterface

@@ src/sspp_parse.sv @@
module sspp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output sspp_pkg::result_t res
);
	import sspp_pkg::*;

	sync_state_t      sync_q, sync_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       err_q, err_d;

	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] csum_pos;
	logic [CNT_W-1:0] pidx_full;
	logic [7:0]       sum_add;
	logic             is_csum;
	logic             csum_ok;

	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign csum_pos  = CNT_W'(len_q) + CNT_W'(2);
	assign pidx_full = cnt_inc - CNT_W'(4);
	assign sum_add   = sum_q + rx_byte;
	assign is_csum   = cnt_inc >= csum_pos;
	assign csum_ok   = (err_q != 8'd0) || (~sum_q == rx_byte);

	always_comb begin
		sync_d = sync_q;
		cnt_d  = cnt_q;
		len_d  = len_q;
		sum_d  = sum_q;
		err_d  = err_q;
		unique case (sync_q)
			ST_SYNC1: begin
				sync_d = (rx_byte == SYNC_BYTE) ? ST_FRAME : ST_HUNT;
			end
			ST_FRAME: begin
				cnt_d = cnt_inc;
				priority if (cnt_inc == CNT_W'(1)) begin
					sum_d = sum_add;
				end else if (cnt_inc == CNT_W'(2)) begin
					if (rx_byte < 8'd2) begin
						sync_d = ST_HUNT;
						cnt_d  = '0;
						len_d  = '0;
						sum_d  = '0;
						err_d  = '0;
					end else begin
						len_d = rx_byte;
						sum_d = sum_add;
					end
				end else if (cnt_inc == CNT_W'(3)) begin
					err_d = rx_byte;
					sum_d = sum_add;
				end else if (is_csum) begin
					sync_d = ST_HUNT;
					cnt_d  = '0;
					len_d  = '0;
					sum_d  = '0;
					err_d  = '0;
				end else begin
					sum_d = sum_add;
				end
			end
			default: begin
				sync_d = (rx_byte == SYNC_BYTE) ? ST_SYNC1 : ST_HUNT;
			end
		endcase
	end

	always_comb begin
		res.frame_status = STAT_BUSY;
		res.byte_role    = ROLE_IDLE;
		res.param_index  = 8'd0;
		res.byte_value   = rx_byte;
		res.servo_error  = err_q;
		unique case (sync_q)
			ST_FRAME: begin
				priority if (cnt_inc == CNT_W'(1)) begin
					res.byte_role = ROLE_ID;
				end else if (cnt_inc == CNT_W'(2)) begin
					res.byte_role = ROLE_LEN;
					if (rx_byte < 8'd2) begin
						res.frame_status = STAT_BAD;
					end
				end else if (cnt_inc == CNT_W'(3)) begin
					res.byte_role   = ROLE_ERR;
					res.servo_error = rx_byte;
				end else if (is_csum) begin
					res.byte_role    = ROLE_CSUM;
					res.frame_status = csum_ok ? STAT_DONE : STAT_BAD;
				end else begin
					res.byte_role   = ROLE_PARAM;
					res.param_index = pidx_full[7:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= ST_HUNT;
			cnt_q  <= '0;
			len_q  <= '0;
			sum_q  <= '0;
			err_q  <= '0;
		end else if (step) begin
			sync_q <= sync_d;
			cnt_q  <= cnt_d;
			len_q  <= len_d;
			sum_q  <= sum_d;
			err_q  <= err_d;
		end
	end

`ifndef SYNTH
	a_csum_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.byte_role == ROLE_CSUM) |=> (sync_q == ST_HUNT && cnt_q == '0))
		else $error("frame state not cleared after checksum item");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.frame_status != STAT_BUSY) |->
		(res.byte_role == ROLE_LEN || res.byte_role == ROLE_CSUM))
		else $error("frame verdict on an item that cannot end a frame");

	a_count_zero_outside_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(sync_q != ST_FRAME) |-> (cnt_q == '0 && sum_q == 8'd0))
		else $error("frame counters live outside a frame");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(sync_q == ST_FRAME && cnt_q > CNT_W'(2)) |-> (cnt_q < csum_pos))
		else $error("byte count ran past the checksum position");
`endif

endmodule

@@ src/servo_status_packet_parser.sv @@
// Status packet parser for a half-duplex servo link. Each received byte is one
// input item and yields exactly one result item carrying the byte, its role in
// the frame, its parameter index and the current servo error byte; the item on
// the checksum byte, or on a length below two, carries the frame verdict. The
// block sustains one item per clock cycle unless a held result is not yet taken:
// the byte is registered, the parser updates its frame state from it, and the
// result is held in an output register until it is taken.
module servo_status_packet_parser (
	input  logic       clk,
	input  logic       arst_n,
	sspp_rx_if.sink    rx,
	sspp_res_if.source res
);
	import sspp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_q;
	result_t    res_q;
	result_t    parse_res;
	logic       advance;
	logic       step;

	assign advance  = !res_valid_q || res.ready;
	assign step     = advance && valid_s1;
	assign rx.ready = !valid_s1 || advance;

	sspp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (parse_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (step) begin
			res_q <= parse_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.frame_status = res_q.frame_status;
	assign res.byte_role    = res_q.byte_role;
	assign res.param_index  = res_q.param_index;
	assign res.byte_value   = res_q.byte_value;
	assign res.servo_error  = res_q.servo_error;

endmodule

@@ tb/frame_parse_monitor.sv @@
`timescale 1ns / 1ps

module frame_parse_monitor (
	input  logic clk,
	input  logic arst_n,
	sspp_rx_if   rx,
	sspp_res_if  res,
	output int   mismatches,
	output int   pending,
	output int   frames_good,
	output int   frames_bad,
	output int   top_param_index
);
	import sspp_pkg::*;

	sync_state_t link_st;
	logic [8:0]  frame_pos;
	logic [7:0]  frame_len;
	logic [7:0]  csum_acc;
	logic [7:0]  servo_err;
	result_t     echo_q[$];

	task automatic clear_frame();
		link_st   = ST_HUNT;
		frame_pos = '0;
		frame_len = '0;
		csum_acc  = '0;
		servo_err = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, output result_t r);
		logic close;
		close            = 1'b0;
		r                = '0;
		r.frame_status   = STAT_BUSY;
		r.byte_role      = ROLE_IDLE;
		r.byte_value     = b;
		case (link_st)
		ST_SYNC1: begin
			link_st = (b == SYNC_BYTE) ? ST_FRAME : ST_HUNT;
		end
		ST_FRAME: begin
			frame_pos = frame_pos + 9'd1;
			if (frame_pos == 9'd1) begin
				r.byte_role = ROLE_ID;
				csum_acc    = csum_acc + b;
			end else if (frame_pos == 9'd2) begin
				r.byte_role = ROLE_LEN;
				if (b < 8'd2) begin
					r.frame_status = STAT_BAD;
					close          = 1'b1;
				end else begin
					frame_len = b;
					csum_acc  = csum_acc + b;
				end
			end else if (frame_pos == 9'd3) begin
				r.byte_role = ROLE_ERR;
				servo_err   = b;
				csum_acc    = csum_acc + b;
			end else if (frame_pos >= 9'd2 + {1'b0, frame_len}) begin
				r.byte_role    = ROLE_CSUM;
				r.frame_status = (servo_err != 8'd0 || ~csum_acc == b) ? STAT_DONE : STAT_BAD;
				close          = 1'b1;
			end else begin
				r.byte_role   = ROLE_PARAM;
				r.param_index = 8'(frame_pos - 9'd4);
				csum_acc      = csum_acc + b;
			end
		end
		default: begin
			link_st = (b == SYNC_BYTE) ? ST_SYNC1 : ST_HUNT;
		end
		endcase
		r.servo_error = servo_err;
		if (close)
			clear_frame();
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t next_want;
		if (!arst_n) begin
			clear_frame();
			echo_q.delete();
			mismatches      = 0;
			pending         = 0;
			frames_good     = 0;
			frames_bad      = 0;
			top_param_index = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (echo_q.size() == 0) begin
					$error("result item with no item pending, byte_value %0d", res.byte_value);
					mismatches++;
				end else begin
					want = echo_q.pop_front();
					check_field("frame_status", 8'(want.frame_status), 8'(res.frame_status));
					check_field("byte_role", 8'(want.byte_role), 8'(res.byte_role));
					check_field("param_index", want.param_index, res.param_index);
					check_field("byte_value", want.byte_value, res.byte_value);
					check_field("servo_error", want.servo_error, res.servo_error);
				end
				if (res.frame_status == STAT_DONE)
					frames_good++;
				if (res.frame_status == STAT_BAD)
					frames_bad++;
				if (res.byte_role == ROLE_PARAM && int'(res.param_index) > top_param_index)
					top_param_index = int'(res.param_index);
			end
			if (rx.valid && rx.ready) begin
				parse_byte(rx.rx_byte, next_want);
				echo_q.push_back(next_want);
			end
			pending = echo_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import sspp_pkg::*;

	logic clk;
	logic arst_n;
	bit   idle_on;
	bit   hold_req;
	int   bytes_sent;
	int   mismatches;
	int   pending;
	int   frames_good;
	int   frames_bad;
	int   top_param_index;

	sspp_rx_if  rx();
	sspp_res_if res();

	servo_status_packet_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res)
	);

	frame_parse_monitor mon (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res),
		.mismatches(mismatches),
		.pending(pending),
		.frames_good(frames_good),
		.frames_bad(frames_bad),
		.top_param_index(top_param_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("servo_status_packet_parser test failed");
		$finish;
	end

	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res.ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				res.ready <= !(idle_on && $urandom_range(99) < 19);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (idle_on && $urandom_range(99) < 19) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(negedge clk);
		while (!rx.ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input logic [7:0] err,
	                          input bit bad_csum);
		logic [7:0] sum;
		logic [7:0] p;
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(id);
		send_byte(len);
		if (len < 8'd2)
			return;
		send_byte(err);
		sum = id + len + err;
		for (int i = 0; i < int'(len) - 2; i++) begin
			p   = 8'($urandom);
			sum = sum + p;
			send_byte(p);
		end
		if (bad_csum)
			send_byte(~sum ^ 8'($urandom_range(255, 1)));
		else
			send_byte(~sum);
	endtask

	initial begin
		logic [7:0] directed [26];
		int         pick;
		logic [7:0] flen;
		bit         drained;
		bit         big_sent;

		directed = '{
			8'hFF, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFE,
			8'hFF, 8'hFF, 8'h00, 8'h01,
			8'hFF, 8'hFF, 8'h01, 8'h03, 8'h80, 8'h55, 8'h00,
			8'hFF, 8'hFF, 8'h02, 8'h03, 8'h00, 8'hAA, 8'h00
		};
		arst_n     = 1'b0;
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		idle_on    = 1'b1;
		hold_req   = 1'b0;
		bytes_sent = 0;
		drained    = 1'b0;
		big_sent   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_byte(directed[i]);

		// The output side stalls for a long stretch while bytes keep coming.
		hold_req = 1'b1;

		while (bytes_sent < 850) begin
			if (!drained && bytes_sent >= 400) begin
				rx.valid <= 1'b0;
				@(negedge clk);
				wait (pending == 0);
				@(posedge clk);
				drained = 1'b1;
			end
			idle_on = !(bytes_sent >= 450 && bytes_sent < 650);
			if (!big_sent && bytes_sent >= 200) begin
				send_frame(8'($urandom), 8'd255, 8'h00, 1'b0);
				big_sent = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				pick = $urandom_range(99);
				if (pick < 5)
					flen = 8'($urandom_range(1));
				else if (pick < 10)
					flen = 8'($urandom_range(40, 9));
				else
					flen = 8'($urandom_range(8, 2));
				send_frame(8'($urandom), flen,
				           ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom),
				           $urandom_range(99) < 15);
			end else if (pick < 85) begin
				repeat ($urandom_range(4, 1))
					send_byte(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
			end else if ($urandom_range(1) == 0) begin
				send_byte(SYNC_BYTE);
				send_byte(8'($urandom_range(254)));
			end else begin
				send_byte(SYNC_BYTE);
				send_byte(SYNC_BYTE);
				send_byte(8'($urandom));
				send_byte(8'($urandom_range(8, 2)));
				repeat ($urandom_range(3))
					send_byte(8'($urandom));
			end
		end
		rx.valid <= 1'b0;

		@(negedge clk);
		wait (pending == 0);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes through sync hunting, short, long and broken frames.",
		         bytes_sent);
		$display("Frames closed good: %0d, closed bad: %0d, highest parameter index: %0d.",
		         frames_good, frames_bad, top_param_index);
		if (mismatches == 0) begin
			$display("servo_status_packet_parser test passed");
		end else begin
			$display("servo_status_packet_parser test failed");
		end
		$finish;
	end

endmodule
